@@ src/skf_pkg.sv @@
// skf_pkg: types, constants and state encoding for the scalar Kalman bank.
// No dependencies; used by every module in src.
package skf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int AXES      = 3;
    localparam int CHANNELS  = 2 * AXES;
    localparam int CH_W      = $clog2(CHANNELS);
    localparam int AX_W      = 2;
    localparam int DIV_W     = 32 + FRAC_BITS;   // dividend width
    localparam int DIVC_W    = $clog2(DIV_W + 1);

    localparam logic [31:0] ONE_FIX = 32'(1) << FRAC_BITS;
    localparam logic [31:0] Q_RESET = 32'd655;
    localparam logic [31:0] R_RESET = 32'd6554;

    localparam logic [1:0] REG_GYRO_Q  = 2'd0;
    localparam logic [1:0] REG_GYRO_R  = 2'd1;
    localparam logic [1:0] REG_ACCEL_Q = 2'd2;
    localparam logic [1:0] REG_ACCEL_R = 2'd3;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] meas_roll;
        logic signed [31:0] meas_pitch;
        logic signed [31:0] meas_yaw;
    } in_item_t;

    typedef struct packed {
        logic               group;
        logic signed [31:0] est_roll;
        logic signed [31:0] est_pitch;
        logic signed [31:0] est_yaw;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_MUL,
        ST_WRITE,
        ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic           capture;    // latch input item
        logic           load;       // load channel, form Ppred and start divide
        logic           div_step;   // one restoring divide step
        logic           mul;        // register products
        logic           write;      // write back channel, store axis result
        logic [AX_W-1:0] axis;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic primed;
    } sts_t;

endpackage

@@ src/skf_ctrl.sv @@
// skf_ctrl: sequencer walking the axes of one item through load, divide,
// multiply, write back (unseeded: load, write back). Depends on skf_pkg.
module skf_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output skf_pkg::cmd_t cmd,
    input  skf_pkg::sts_t sts
);

    skf_pkg::state_t state_reg, state_next;
    logic [skf_pkg::AX_W-1:0] axis_reg, axis_next;
    logic last_axis;

    assign last_axis = (axis_reg == skf_pkg::AX_W'(skf_pkg::AXES - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skf_pkg::ST_IDLE;
            axis_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        unique case (state_reg)
            skf_pkg::ST_IDLE:
                if (in_valid)
                begin
                    state_next = skf_pkg::ST_LOAD;
                    axis_next  = '0;
                end
            skf_pkg::ST_LOAD:
                state_next = sts.primed ? skf_pkg::ST_DIV : skf_pkg::ST_WRITE;
            skf_pkg::ST_DIV:
                if (sts.div_done)
                    state_next = skf_pkg::ST_MUL;
            skf_pkg::ST_MUL:
                state_next = skf_pkg::ST_WRITE;
            skf_pkg::ST_WRITE:
                if (last_axis)
                    state_next = skf_pkg::ST_OUT;
                else
                begin
                    state_next = skf_pkg::ST_LOAD;
                    axis_next  = axis_reg + 1'b1;
                end
            skf_pkg::ST_OUT:
                if (!out_stall)
                    state_next = skf_pkg::ST_IDLE;
            default:
                state_next = skf_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.axis     = axis_reg;
        in_stall     = 1'b1;
        out_valid    = 1'b0;
        unique case (state_reg)
            skf_pkg::ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            skf_pkg::ST_LOAD:  cmd.load     = 1'b1;
            skf_pkg::ST_DIV:   cmd.div_step = 1'b1;
            skf_pkg::ST_MUL:   cmd.mul      = 1'b1;
            skf_pkg::ST_WRITE: cmd.write    = 1'b1;
            skf_pkg::ST_OUT:   out_valid    = 1'b1;
            default:           cmd          = '0;
        endcase
    end

endmodule

@@ src/skf_datapath.sv @@
// skf_datapath: channel state, noise registers, shared restoring divider and
// the gain multiplies. Depends on skf_pkg.
module skf_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  skf_pkg::in_item_t   in_data,
    output skf_pkg::out_item_t  out_data,
    input  skf_pkg::cmd_t       cmd,
    output skf_pkg::sts_t       sts
);

    localparam int F = skf_pkg::FRAC_BITS;
    localparam int N = skf_pkg::DIV_W;

    logic [31:0] gq_reg, gr_reg, aq_reg, ar_reg;
    logic signed [31:0] est_reg [skf_pkg::CHANNELS];
    logic [31:0]        var_reg [skf_pkg::CHANNELS];
    logic [skf_pkg::CHANNELS-1:0] primed_reg;

    skf_pkg::in_item_t  item_reg;
    skf_pkg::out_item_t res_reg;

    logic [skf_pkg::CH_W-1:0] ch;
    logic signed [31:0] z, x;
    logic [31:0] ppred_reg;
    logic [32:0] den_reg;
    logic [N-1:0] quo_reg;
    logic [32:0] rem_reg;
    logic [skf_pkg::DIVC_W-1:0] cnt_reg;
    logic [31:0] q_sel, r_sel;
    logic [32:0] ppsum;
    logic [31:0] ppred_c;
    logic [33:0] rem_sh, rem_sub;
    logic [F:0] k;
    logic signed [F+1+33:0] kd_reg;
    logic [F+32:0] pv_reg;
    logic signed [32:0] diff;
    logic signed [32:0] dx;
    logic signed [32:0] est_new;

    assign ch = skf_pkg::CH_W'(item_reg.mode * skf_pkg::AXES) + skf_pkg::CH_W'(cmd.axis);
    assign q_sel = item_reg.mode ? aq_reg : gq_reg;
    assign r_sel = item_reg.mode ? ar_reg : gr_reg;

    always_comb
    begin
        unique case (cmd.axis)
            2'd0:    z = item_reg.meas_roll;
            2'd1:    z = item_reg.meas_pitch;
            default: z = item_reg.meas_yaw;
        endcase
    end
    assign x = est_reg[ch];

    assign ppsum   = {1'b0, var_reg[ch]} + {1'b0, q_sel};
    assign ppred_c = ppsum[32] ? 32'hFFFF_FFFF : ppsum[31:0];

    assign rem_sh  = {rem_reg, quo_reg[N-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    // gain is clamped to 1.0; zero denominator gives a gain of zero
    assign k = (den_reg == '0) ? '0
             : (quo_reg > N'(skf_pkg::ONE_FIX)) ? (F+1)'(skf_pkg::ONE_FIX)
             : quo_reg[F:0];
    assign diff = 33'(z) - 33'(x);

    assign dx      = 33'(kd_reg >>> F);
    assign est_new = 33'(x) + dx;

    assign sts.div_done = (cnt_reg == '0);
    assign sts.primed   = primed_reg[ch];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gq_reg     <= skf_pkg::Q_RESET;
            gr_reg     <= skf_pkg::R_RESET;
            aq_reg     <= skf_pkg::Q_RESET;
            ar_reg     <= skf_pkg::R_RESET;
            primed_reg <= '0;
            for (int i = 0; i < skf_pkg::CHANNELS; i++)
            begin
                est_reg[i] <= '0;
                var_reg[i] <= skf_pkg::ONE_FIX;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    skf_pkg::REG_GYRO_Q:  gq_reg <= cfg_data;
                    skf_pkg::REG_GYRO_R:  gr_reg <= cfg_data;
                    skf_pkg::REG_ACCEL_Q: aq_reg <= cfg_data;
                    skf_pkg::REG_ACCEL_R: ar_reg <= cfg_data;
                    default:              gq_reg <= gq_reg;
                endcase
            end
            if (cmd.write)
            begin
                primed_reg[ch] <= 1'b1;
                if (!primed_reg[ch])
                begin
                    est_reg[ch] <= z;
                    var_reg[ch] <= skf_pkg::ONE_FIX;
                end
                else
                begin
                    est_reg[ch] <= est_new[31:0];
                    var_reg[ch] <= pv_reg[F+31:F];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_data;
            res_reg  <= '{group: in_data.mode, default: '0};
        end
        if (cmd.load)
        begin
            ppred_reg <= ppred_c;
            den_reg   <= {1'b0, ppred_c} + {1'b0, r_sel};
            quo_reg   <= {ppred_c, F'(0)};
            rem_reg   <= '0;
            cnt_reg   <= skf_pkg::DIVC_W'(N);
        end
        if (cmd.div_step && cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (!rem_sub[33])
            begin
                rem_reg <= rem_sub[32:0];
                quo_reg <= {quo_reg[N-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[32:0];
                quo_reg <= {quo_reg[N-2:0], 1'b0};
            end
        end
        if (cmd.mul)
        begin
            kd_reg <= $signed({1'b0, k}) * diff;
            pv_reg <= ((F+1)'(skf_pkg::ONE_FIX) - k) * ppred_reg;
        end
        if (cmd.write)
        begin
            unique case (cmd.axis)
                2'd0:    res_reg.est_roll  <= primed_reg[ch] ? est_new[31:0] : z;
                2'd1:    res_reg.est_pitch <= primed_reg[ch] ? est_new[31:0] : z;
                default: res_reg.est_yaw   <= primed_reg[ch] ? est_new[31:0] : z;
            endcase
        end
    end

    assign out_data = res_reg;

endmodule

@@ src/six_channel_scalar_kalman.sv @@
// six_channel_scalar_kalman: top level of the six-channel scalar Kalman bank.
// Depends on skf_pkg, skf_ctrl and skf_datapath.
//
// One input transaction carries a group select (gyro or accel) and three
// signed Q16.16 samples; one output transaction returns the group's three new
// estimates. Items are handled one at a time: the three axes share one
// restoring divider that retires one quotient bit per cycle over 48 steps.
// Each seeded axis takes load, divide, multiply and write back; an axis still
// being seeded by its first sample takes only load and write back. A result is
// offered once all three axes are written back, and a new item is accepted
// only after the result is taken and the block is idle again. Noise registers
// are to be written through the cfg port only while no item is in flight; the
// block itself does not enforce this.
module six_channel_scalar_kalman (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  skf_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output skf_pkg::out_item_t  out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    skf_pkg::cmd_t cmd;
    skf_pkg::sts_t sts;

    skf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    skf_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    // never accept while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && !in_stall))
        else $error("input accepted while result pending");

    // an accepted item leaves the idle state
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("ready after accept");

    // commands are mutually exclusive
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.load, cmd.div_step, cmd.mul, cmd.write}))
        else $error("overlapping datapath commands");

endmodule

@@ bench/six_channel_scalar_kalman_chk.sv @@
// Checker for the six-channel scalar Kalman bank: predicts each result from the
// input transactions and compares it with the block's output. Depends on skf_pkg.
module six_channel_scalar_kalman_chk
    import skf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  in_item_t    in_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  out_item_t   out_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0]        noise_q [2];
    logic [31:0]        noise_r [2];
    logic signed [31:0] est_mem [CHANNELS];
    logic [31:0]        var_mem [CHANNELS];
    logic               seeded  [CHANNELS];
    out_item_t          est_queue [$];

    assign pending = est_queue.size();

    // One filter step on one channel; returns the new estimate.
    function automatic logic signed [31:0] kalman_step(int ch, logic signed [31:0] z,
                                                       logic [31:0] q, logic [31:0] r);
        logic [32:0]        ppred;
        logic [33:0]        denom;
        logic [63:0]        gain;
        logic signed [33:0] diff;
        logic signed [65:0] prod;
        logic [65:0]        pnew;
        if (!seeded[ch])
        begin
            seeded[ch]  = 1'b1;
            est_mem[ch] = z;
            var_mem[ch] = ONE_FIX;
            return z;
        end
        ppred = {1'b0, var_mem[ch]} + {1'b0, q};
        if (ppred[32])
            ppred = 33'h0_FFFF_FFFF;
        denom = {1'b0, ppred} + {2'b0, r};
        gain = (denom == 0) ? 64'd0 : ({31'd0, ppred} << FRAC_BITS) / {30'd0, denom};
        if (gain > ONE_FIX)
            gain = ONE_FIX;
        diff = 34'(z) - 34'(est_mem[ch]);
        prod = $signed({1'b0, gain[32:0]}) * diff;
        est_mem[ch] = 32'(est_mem[ch] + (prod >>> FRAC_BITS));
        pnew = (66'(ONE_FIX) - 66'(gain)) * 66'(ppred);
        var_mem[ch] = 32'(pnew >> FRAC_BITS);
        return est_mem[ch];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_item;
        int        g;
        if (!rst_n)
        begin
            noise_q = '{Q_RESET, Q_RESET};
            noise_r = '{R_RESET, R_RESET};
            for (int i = 0; i < CHANNELS; i++)
            begin
                est_mem[i] = '0;
                var_mem[i] = ONE_FIX;
                seeded[i]  = 1'b0;
            end
            est_queue.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_we)
                case (cfg_index)
                    REG_GYRO_Q:  noise_q[0] = cfg_data;
                    REG_GYRO_R:  noise_r[0] = cfg_data;
                    REG_ACCEL_Q: noise_q[1] = cfg_data;
                    REG_ACCEL_R: noise_r[1] = cfg_data;
                    default: ;
                endcase
            if (in_valid && !in_stall)
            begin
                g = int'(in_data.mode);
                exp_item.group     = in_data.mode;
                exp_item.est_roll  = kalman_step(g * AXES + 0, in_data.meas_roll,
                                                 noise_q[g], noise_r[g]);
                exp_item.est_pitch = kalman_step(g * AXES + 1, in_data.meas_pitch,
                                                 noise_q[g], noise_r[g]);
                exp_item.est_yaw   = kalman_step(g * AXES + 2, in_data.meas_yaw,
                                                 noise_q[g], noise_r[g]);
                est_queue.push_back(exp_item);
            end
            if (out_valid && !out_stall)
            begin
                if (est_queue.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $realtime, out_data);
                    errors++;
                end
                else
                begin
                    exp_item = est_queue.pop_front();
                    if (exp_item !== out_data)
                    begin
                        $display("%0t: mismatch expected g=%0d %h %h %h actual g=%0d %h %h %h",
                                 $realtime, exp_item.group, exp_item.est_roll,
                                 exp_item.est_pitch, exp_item.est_yaw, out_data.group,
                                 out_data.est_roll, out_data.est_pitch, out_data.est_yaw);
                        errors++;
                    end
                end
            end
        end
    end
endmodule

@@ bench/six_channel_scalar_kalman_tb.sv @@
// Top of the Kalman bank testbench: clock, reset, stimulus and verdict.
// Depends on skf_pkg, six_channel_scalar_kalman and six_channel_scalar_kalman_chk.
module six_channel_scalar_kalman_tb;
    import skf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CYCLES = 2000000;
    localparam int DRAIN      = 400;    // extra wait after the checker queue empties

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_GYRO_Q;
    logic [31:0] cfg_data = '0;
    int          errors;
    int          pending;
    int          cycles = 0;
    bit          calm = 1'b0;    // no idling at the end of the run

    always #10 clk = ~clk;

    six_channel_scalar_kalman u_top (.*);

    six_channel_scalar_kalman_chk u_chk (.*);

    // Hard limit on run length
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES)
        begin
            $display("six_channel_scalar_kalman_tb: FAIL");
            $finish;
        end
    end

    // Receiver stalls in random bursts
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 16);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    // Sample value biased toward extremes and small values
    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
            3: return 32'($urandom_range(0, 255)) ^ {32{$urandom_range(0, 1) == 1}};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_noise();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 65536 * 4);
            default: return $urandom_range(1, 20000);
        endcase
    endfunction

    // Send one input transaction, with an optional gap before it
    task automatic send_sample(logic grp, logic [31:0] r, logic [31:0] p, logic [31:0] y);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{grp, r, p, y};
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain_block();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    // One register write, then the write enable is driven low again
    task automatic write_noise(logic [1:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: seeding on both groups with extreme samples, then steps
        send_sample(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        send_sample(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_sample(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
        send_sample(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        send_sample(1'b0, 32'hFFFF_FFFF, 32'h0, 32'hAAAA_5555);
        send_sample(1'b1, 32'h5555_AAAA, 32'h1, 32'hFFFF_0000);
        drain_block();

        // Zero gyro noise: denominator collapses to zero once variance hits zero
        write_noise(REG_GYRO_Q, 32'h0);
        write_noise(REG_GYRO_R, 32'h0);
        write_noise(REG_ACCEL_Q, 32'hFFFF_FFFF);
        write_noise(REG_ACCEL_R, 32'hFFFF_FFFF);
        for (int i = 0; i < 8; i++)
            send_sample(i[0], pick_sample(), pick_sample(), pick_sample());
        // Variance overflow: huge Q saturates the predicted variance
        drain_block();
        write_noise(REG_GYRO_Q, 32'hFFFF_FFFF);
        write_noise(REG_GYRO_R, 32'h0);
        write_noise(REG_ACCEL_Q, 32'h0);
        write_noise(REG_ACCEL_R, 32'h0);
        for (int i = 0; i < 6; i++)
            send_sample(i[0], pick_sample(), pick_sample(), pick_sample());
        drain_block();

        // Random phases with varied noise settings; last phase without idling
        for (int ph = 0; ph < 10; ph++)
        begin
            if (ph == 9)
            begin
                write_noise(REG_GYRO_Q, Q_RESET);
                write_noise(REG_GYRO_R, R_RESET);
                calm = 1'b1;
            end
            else
            begin
                write_noise(REG_GYRO_Q, pick_noise());
                write_noise(REG_GYRO_R, pick_noise());
            end
            write_noise(REG_ACCEL_Q, pick_noise());
            write_noise(REG_ACCEL_R, pick_noise());
            for (int i = 0; i < 113; i++)
                send_sample(1'($urandom_range(0, 1)), pick_sample(), pick_sample(),
                            pick_sample());
            drain_block();
        end

        if (errors == 0)
            $display("six_channel_scalar_kalman_tb: PASS");
        else
            $display("six_channel_scalar_kalman_tb: FAIL");
        $finish;
    end
endmodule
